>>> design/swza_pkg.sv
// Shared types and constants for the sliding-window z-score anomaly detector.
// No dependencies; used by swza_div and sliding_window_zscore_anomaly.
`default_nettype none

package swza_pkg;

    localparam int SAMPLE_W  = 16;  // Q3.12 sample
    localparam int LEN_W     = 7;   // window_length register
    localparam int COEF_W    = 16;  // threshold and damping coefficients
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int VAR_W     = 36;  // Q12.24 variance
    localparam int VAR_HALF  = VAR_W / 2;
    localparam int DIV_STEPS = 4;   // quotient bits per divider cycle

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING       = 2'd2;

    localparam logic [LEN_W-1:0]  WINDOW_LENGTH_RST = 7'd24;
    localparam logic [COEF_W-1:0] THRESHOLD_RST     = 16'd1582;
    localparam logic [COEF_W-1:0] DAMPING_RST       = 16'd24379;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

>>> design/swza_div.sv
// Iterative unsigned divider, DIV_STEPS quotient bits per cycle, narrow divisor.
// Depends on swza_pkg.
`default_nettype none

module swza_div
    import swza_pkg::*;
#(
    parameter int DIVIDEND_W = 44
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [LEN_W-1:0]      divisor,
    output logic      [DIVIDEND_W-1:0] quotient,
    output div_stat_t                  stat
);

    localparam int PASSES = DIVIDEND_W / DIV_STEPS;
    localparam int CNT_W  = $clog2(PASSES + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [LEN_W-1:0]      rem_reg, rem_next;
    logic [LEN_W-1:0]      dsr_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg, done_reg;

    logic [LEN_W-1:0]      r;
    logic [DIVIDEND_W-1:0] q;
    logic [LEN_W:0]        t;

    always_comb begin
        r = rem_reg;
        q = quo_reg;
        t = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            t = {r, q[DIVIDEND_W-1]};
            q = {q[DIVIDEND_W-2:0], 1'b0};
            if (t >= {1'b0, dsr_reg}) begin
                t    = t - {1'b0, dsr_reg};
                q[0] = 1'b1;
            end
            r = t[LEN_W-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(PASSES);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

>>> design/sliding_window_zscore_anomaly.sv
// Sliding-window z-score detector for low-going anomalies: top level, sequencer,
// shared multiplier and window store. Depends on swza_pkg and swza_div.
//
//  channel | prefix | payload
//  --------+--------+--------------------------------------------------------
//  input   | s_     | tdata[15:0] sample
//  result  | m_     | tdata[15:0] stored_value; tuser[0] anomaly, [1] window_ready
//  config  | cfg_   | index[1:0] register, data[15:0] value
//
// A warm-up sample is written to the window store and passed on as the result. The last
// warm-up sample and each sample with a full window take up to three passes through the
// divider: the mean, the squared-sum term and, unless its numerator is negative, the variance.
// One sample is in work at a time; s_tready is high only while the sequencer is idle.
// A held result stalls the sequencer only in its last step. aresetn is synchronous;
// the window store itself is not cleared, its entries are read only after a write.
`default_nettype none

module sliding_window_zscore_anomaly
    import swza_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [SAMPLE_W-1:0]  s_tdata,     // [15:0] sample
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [SAMPLE_W-1:0]  m_tdata,     // [15:0] stored_value
    output logic      [1:0]           m_tuser,     // [0] anomaly, [1] window_ready
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW      = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
    localparam int LEN_MAX = (1 << LEN_W) - 1;
    localparam int LEN_CAP = (MAX_WINDOW > LEN_MAX) ? LEN_MAX : MAX_WINDOW;
    localparam int SUM_W   = SAMPLE_W + AW;
    localparam int SQ_W    = 2 * SAMPLE_W + AW;
    localparam int MUL_RAW = (SUM_W > VAR_HALF + 1) ? SUM_W : VAR_HALF + 1;
    localparam int MUL_W   = MUL_RAW + (MUL_RAW % 2);
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DIVW    = PROD_W;
    localparam int D_W     = SAMPLE_W + 1;
    localparam int LHS_W   = 2 * D_W + 8;
    localparam int RHS_W   = COEF_W + VAR_W;
    localparam int DAMP_W  = 2 * SAMPLE_W + 2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START, ST_WARM, ST_OLD, ST_OLDSQ, ST_TF_LO, ST_TF_HI, ST_CMP,
        ST_DAMP1, ST_DAMP2, ST_NEWSQ, ST_UPD, ST_MEAN_GO, ST_MEAN_WAIT, ST_SQ,
        ST_Q_GO, ST_Q_WAIT, ST_VAR_GO, ST_VAR_WAIT, ST_OUT
    } state_t;

    state_t state_reg;

    logic [LEN_W-1:0]         wl_reg;
    logic [COEF_W-1:0]        tf_reg, dw_reg;
    logic [AW-1:0]            pos_reg;
    logic [CW-1:0]            fill_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SQ_W-1:0]   sqsum_reg;
    logic signed [SAMPLE_W-1:0] mean_reg;
    logic [VAR_W-1:0]         var_reg;

    logic signed [SAMPLE_W-1:0] s_reg, old_reg, newest_reg, rd_reg;
    logic signed [D_W-1:0]    d_reg;
    logic [SQ_W-1:0]          oldsq_reg;
    logic [LHS_W-1:0]         lhs_reg;
    logic [RHS_W-1:0]         rhs_reg;
    logic [DAMP_W-1:0]        acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     anomaly_reg;

    logic                     m_tvalid_reg;
    logic [SAMPLE_W-1:0]      m_tdata_reg;
    logic [1:0]               m_tuser_reg;

    logic [SAMPLE_W-1:0]      win_mem [MAX_WINDOW];
    logic [AW-1:0]            rd_addr;
    logic                     mem_we;

    logic [LEN_W-1:0]         len_short;
    logic [CW-1:0]            eff_len, pos_ext, newest_ext, pos_next;
    logic                     warm;
    logic signed [D_W-1:0]    d_next;
    logic                     d_pos;
    logic [SUM_W-1:0]         abs_sum;
    logic [COEF_W:0]          w_comp;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic [RHS_W-1:0]         rhs_full;
    logic [DAMP_W-1:0]        damp_sum;
    logic [SQ_W:0]            var_num;

    logic                     div_start;
    logic [DIVW-1:0]          div_dividend;
    logic [LEN_W-1:0]         div_divisor;
    logic [DIVW-1:0]          div_quo;
    div_stat_t                div_stat;

    always_comb begin
        if (wl_reg < LEN_W'(2)) begin
            len_short = LEN_W'(2);
        end else if (wl_reg > LEN_W'(LEN_CAP)) begin
            len_short = LEN_W'(LEN_CAP);
        end else begin
            len_short = wl_reg;
        end
    end

    assign eff_len    = CW'(len_short);
    assign pos_ext    = CW'(pos_reg);
    assign newest_ext = (pos_reg == '0) ? eff_len - CW'(1) : pos_ext - CW'(1);
    assign pos_next   = (pos_ext + CW'(1) == eff_len) ? '0 : pos_ext + CW'(1);
    assign warm       = fill_reg < eff_len;
    assign d_next     = D_W'(mean_reg) - D_W'(s_reg);
    assign d_pos      = !d_reg[D_W-1] && (d_reg != '0);
    assign abs_sum    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign w_comp     = {1'b1, COEF_W'(0)} - {1'b0, dw_reg};
    assign rhs_full   = rhs_reg + {prod_reg[RHS_W-VAR_HALF-1:0], VAR_HALF'(0)};
    assign damp_sum   = acc_reg + prod_reg[DAMP_W-1:0] + DAMP_W'(32768);
    assign var_num    = {sqsum_reg[SQ_W-1], sqsum_reg} - {1'b0, div_quo[SQ_W-1:0]};

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_START, ST_NEWSQ: begin
                mul_a = MUL_W'(s_reg);
                mul_b = MUL_W'(s_reg);
            end
            ST_OLD: begin
                mul_a = MUL_W'(rd_reg);
                mul_b = MUL_W'(rd_reg);
            end
            ST_OLDSQ: begin
                mul_a = MUL_W'(d_reg);
                mul_b = MUL_W'(d_reg);
            end
            ST_TF_LO: begin
                mul_a = MUL_W'(tf_reg);
                mul_b = MUL_W'(var_reg[VAR_HALF-1:0]);
            end
            ST_TF_HI: begin
                mul_a = MUL_W'(tf_reg);
                mul_b = MUL_W'(var_reg[VAR_W-1:VAR_HALF]);
            end
            ST_CMP: begin
                mul_a = MUL_W'(dw_reg);
                mul_b = MUL_W'(s_reg);
            end
            ST_DAMP1: begin
                mul_a = MUL_W'(w_comp);
                mul_b = MUL_W'(newest_reg);
            end
            ST_SQ: begin
                mul_a = MUL_W'(sum_reg);
                mul_b = MUL_W'(sum_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // divider requests
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = len_short;
        unique case (state_reg)
            ST_MEAN_GO: begin
                div_start    = 1'b1;
                div_dividend = DIVW'(abs_sum);
            end
            ST_Q_GO: begin
                div_start    = 1'b1;
                div_dividend = $unsigned(prod_reg);
            end
            ST_VAR_GO: begin
                div_start    = !var_num[SQ_W];
                div_dividend = DIVW'(var_num[SQ_W-1:0]);
                div_divisor  = len_short - LEN_W'(1);
            end
            default: begin
                div_start    = 1'b0;
            end
        endcase
    end

    swza_div #(
        .DIVIDEND_W (DIVW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // window store
    assign mem_we  = (state_reg == ST_WARM) || (state_reg == ST_UPD);
    assign rd_addr = (state_reg == ST_OLD) ? newest_ext[AW-1:0] : pos_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            win_mem[pos_reg] <= s_reg;
        end
        rd_reg <= win_mem[rd_addr];
    end

    // datapath payload
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            wl_reg       <= WINDOW_LENGTH_RST;
            tf_reg       <= THRESHOLD_RST;
            dw_reg       <= DAMPING_RST;
            pos_reg      <= '0;
            fill_reg     <= '0;
            sum_reg      <= '0;
            sqsum_reg    <= '0;
            mean_reg     <= '0;
            var_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_WINDOW_LENGTH: begin
                        wl_reg    <= cfg_data[LEN_W-1:0];
                        pos_reg   <= '0;
                        fill_reg  <= '0;
                        sum_reg   <= '0;
                        sqsum_reg <= '0;
                        mean_reg  <= '0;
                        var_reg   <= '0;
                    end
                    REG_THRESHOLD: tf_reg <= cfg_data;
                    REG_DAMPING:   dw_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        s_reg       <= s_tdata;
                        anomaly_reg <= 1'b0;
                        state_reg   <= ST_START;
                    end
                end
                ST_START: begin
                    d_reg     <= d_next;
                    state_reg <= warm ? ST_WARM : ST_OLD;
                end
                ST_WARM: begin
                    sum_reg   <= sum_reg + SUM_W'(s_reg);
                    sqsum_reg <= sqsum_reg + prod_reg[SQ_W-1:0];
                    fill_reg  <= fill_reg + CW'(1);
                    pos_reg   <= pos_next[AW-1:0];
                    state_reg <= (fill_reg + CW'(1) == eff_len) ? ST_MEAN_GO : ST_OUT;
                end
                ST_OLD: begin
                    old_reg   <= rd_reg;
                    state_reg <= ST_OLDSQ;
                end
                ST_OLDSQ: begin
                    oldsq_reg  <= prod_reg[SQ_W-1:0];
                    newest_reg <= rd_reg;
                    state_reg  <= d_pos ? ST_TF_LO : ST_NEWSQ;
                end
                ST_TF_LO: begin
                    lhs_reg   <= {prod_reg[2*D_W-1:0], 8'b0};
                    state_reg <= ST_TF_HI;
                end
                ST_TF_HI: begin
                    rhs_reg   <= RHS_W'(prod_reg[COEF_W+VAR_HALF-1:0]);
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    state_reg <= (RHS_W'(lhs_reg) > rhs_full) ? ST_DAMP1 : ST_NEWSQ;
                end
                ST_DAMP1: begin
                    acc_reg   <= prod_reg[DAMP_W-1:0];
                    state_reg <= ST_DAMP2;
                end
                ST_DAMP2: begin
                    s_reg       <= damp_sum[16 +: SAMPLE_W];
                    anomaly_reg <= 1'b1;
                    state_reg   <= ST_NEWSQ;
                end
                ST_NEWSQ: begin
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    sum_reg   <= sum_reg + SUM_W'(s_reg) - SUM_W'(old_reg);
                    sqsum_reg <= sqsum_reg + prod_reg[SQ_W-1:0] - oldsq_reg;
                    pos_reg   <= pos_next[AW-1:0];
                    state_reg <= ST_MEAN_GO;
                end
                ST_MEAN_GO: begin
                    state_reg <= ST_MEAN_WAIT;
                end
                ST_MEAN_WAIT: begin
                    if (div_stat.done) begin
                        mean_reg  <= sum_reg[SUM_W-1]
                                   ? SAMPLE_W'(0) - div_quo[SAMPLE_W-1:0]
                                   : div_quo[SAMPLE_W-1:0];
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    state_reg <= ST_Q_GO;
                end
                ST_Q_GO: begin
                    state_reg <= ST_Q_WAIT;
                end
                ST_Q_WAIT: begin
                    if (div_stat.done) begin
                        state_reg <= ST_VAR_GO;
                    end
                end
                ST_VAR_GO: begin
                    if (var_num[SQ_W]) begin
                        var_reg   <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_VAR_WAIT;
                    end
                end
                ST_VAR_WAIT: begin
                    if (div_stat.done) begin
                        var_reg   <= div_quo[VAR_W-1:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= s_reg;
                        m_tuser_reg  <= {fill_reg >= eff_len, anomaly_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= eff_len)
        else $error("fill count beyond window length");

    a_warm_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg < eff_len) |-> (pos_ext == fill_reg))
        else $error("write position out of step with fill count during warm-up");

    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("divider busy while accepting a sample");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_anom_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tuser[1])
        else $error("anomaly flagged before window full");
`endif

endmodule

`default_nettype wire
